### rtl/core/bgdc_pkg.sv
`default_nettype none

package bgdc_pkg;

    localparam int unsigned TimeW     = 32;
    localparam int unsigned DigitW    = 4;
    localparam int unsigned SegW      = 7;
    localparam int unsigned GestW     = 3;
    localparam int unsigned DebW      = 10;
    localparam int unsigned DblW      = 13;
    localparam int unsigned LongW     = 14;
    localparam int unsigned RepW      = 13;
    localparam int unsigned InDataW   = 40;
    localparam int unsigned OutDataW  = 16;
    localparam int unsigned AddrW     = 5;
    localparam int unsigned ApbDataW  = 32;

    // register indexes (byte address is 4 * index)
    localparam logic [2:0] RegDebounce    = 3'd0;
    localparam logic [2:0] RegDoubleClick = 3'd1;
    localparam logic [2:0] RegLongPress   = 3'd2;
    localparam logic [2:0] RegRepeat      = 3'd3;
    localparam logic [2:0] RegCommonAnode = 3'd4;

    localparam logic [DebW-1:0]  DebounceRst    = 10'd25;
    localparam logic [DblW-1:0]  DoubleClickRst = 13'd350;
    localparam logic [LongW-1:0] LongPressRst   = 14'd800;
    localparam logic [RepW-1:0]  RepeatRst      = 13'd500;

    localparam logic [DigitW-1:0] DigitMax = 4'd9;

    typedef enum logic [GestW-1:0] {
        G_NONE   = 3'd0,
        G_SINGLE = 3'd1,
        G_DOUBLE = 3'd2,
        G_LONG   = 3'd3,
        G_REPEAT = 3'd4
    } t_gesture;

    typedef struct packed {
        logic [DebW-1:0]  deb_time;
        logic [DblW-1:0]  dbl_window;
        logic [LongW-1:0] hold_time;
        logic [RepW-1:0]  rep_period;
        logic             common_anode;
    } t_cfg;

    typedef struct packed {
        logic              filtered_level;
        logic              previous_raw;
        logic [TimeW-1:0]  raw_change_time;
        logic [TimeW-1:0]  press_start_time;
        logic              long_active;
        logic              double_candidate;
        logic [TimeW-1:0]  last_repeat_time;
        logic              click_pending;
        logic [TimeW-1:0]  pending_click_time;
        logic [DigitW-1:0] counter_value;
    } t_state;

    typedef struct packed {
        t_gesture          gesture;
        logic              debounced_level;
        logic [SegW-1:0]   segments;
        logic [DigitW-1:0] digit;
    } t_result;

    function automatic logic [SegW-1:0] seg_lookup(input logic [DigitW-1:0] d);
        logic [SegW-1:0] s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h3F;
        endcase
        return s;
    endfunction

    function automatic logic [DigitW-1:0] digit_up(input logic [DigitW-1:0] d);
        return (d >= DigitMax) ? '0 : d + 4'd1;
    endfunction

    function automatic logic [DigitW-1:0] digit_down(input logic [DigitW-1:0] d);
        return (d == '0) ? DigitMax : d - 4'd1;
    endfunction

endpackage

`default_nettype wire

### rtl/core/button_gesture_digit_counter.sv
// Button gesture digit counter: each input beat is one sample of an active-low
// button with its millisecond timestamp; each sample yields exactly one output
// beat with the digit 0-9, its seven-segment pattern, the debounced level and
// the gesture that fired. One sample is taken every clock cycle while the
// skid entry is empty: the whole state update is a single pass of
// subtract-and-compare logic into the state and result registers. A
// two-entry output buffer keeps the input side ready while one result waits.
// Configuration (APB, one register per word) should be written while idle.
`default_nettype none

module button_gesture_digit_counter (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: raw_level [0], now_ms [32:1], zero [39:33]
    input  wire  [bgdc_pkg::InDataW-1:0]     s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    // tdata: digit [3:0], segments [10:4], debounced_level [11], gesture [14:12], zero [15]
    output logic [bgdc_pkg::OutDataW-1:0]    m_axis_tdata,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [bgdc_pkg::AddrW-1:0]       paddr,
    input  wire  [bgdc_pkg::ApbDataW-1:0]    pwdata,
    output logic [bgdc_pkg::ApbDataW-1:0]    prdata,
    output logic                             pready
);

    bgdc_pkg::t_cfg    r_cfg;
    bgdc_pkg::t_state  r_state, n_state;
    bgdc_pkg::t_result n_result, r_out, r_skd;
    logic              r_out_vld, r_skd_vld;
    logic              in_beat, cfg_wr;
    logic [2:0]        reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deb_time     <= bgdc_pkg::DebounceRst;
            r_cfg.dbl_window   <= bgdc_pkg::DoubleClickRst;
            r_cfg.hold_time    <= bgdc_pkg::LongPressRst;
            r_cfg.rep_period   <= bgdc_pkg::RepeatRst;
            r_cfg.common_anode <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_idx)
                bgdc_pkg::RegDebounce:    r_cfg.deb_time     <= pwdata[bgdc_pkg::DebW-1:0];
                bgdc_pkg::RegDoubleClick: r_cfg.dbl_window   <= pwdata[bgdc_pkg::DblW-1:0];
                bgdc_pkg::RegLongPress:   r_cfg.hold_time    <= pwdata[bgdc_pkg::LongW-1:0];
                bgdc_pkg::RegRepeat:      r_cfg.rep_period   <= pwdata[bgdc_pkg::RepW-1:0];
                bgdc_pkg::RegCommonAnode: r_cfg.common_anode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            bgdc_pkg::RegDebounce:    prdata[bgdc_pkg::DebW-1:0]  = r_cfg.deb_time;
            bgdc_pkg::RegDoubleClick: prdata[bgdc_pkg::DblW-1:0]  = r_cfg.dbl_window;
            bgdc_pkg::RegLongPress:   prdata[bgdc_pkg::LongW-1:0] = r_cfg.hold_time;
            bgdc_pkg::RegRepeat:      prdata[bgdc_pkg::RepW-1:0]  = r_cfg.rep_period;
            bgdc_pkg::RegCommonAnode: prdata[0]                   = r_cfg.common_anode;
            default:                  prdata = '0;
        endcase
    end

    bgdc_step u_step (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_raw_level (s_axis_tdata[0]),
        .i_now_ms    (s_axis_tdata[bgdc_pkg::TimeW:1]),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    assign s_axis_tready = !r_skd_vld;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.filtered_level     <= 1'b1;
            r_state.previous_raw       <= 1'b1;
            r_state.raw_change_time    <= '0;
            r_state.press_start_time   <= '0;
            r_state.long_active        <= 1'b0;
            r_state.double_candidate   <= 1'b0;
            r_state.last_repeat_time   <= '0;
            r_state.click_pending      <= 1'b0;
            r_state.pending_click_time <= '0;
            r_state.counter_value      <= '0;
        end else if (in_beat) begin
            r_state <= n_state;
        end
    end

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (r_skd_vld) begin
            if (m_axis_tready) begin
                r_out     <= r_skd;
                r_skd_vld <= 1'b0;
            end
        end else if (in_beat) begin
            if (!r_out_vld || m_axis_tready) begin
                r_out     <= n_result;
                r_out_vld <= 1'b1;
            end else begin
                r_skd     <= n_result;
                r_skd_vld <= 1'b1;
            end
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_out};

endmodule

`default_nettype wire

### rtl/core/bgdc_step.sv
`default_nettype none

module bgdc_step (
    input  var bgdc_pkg::t_cfg                     i_cfg,
    input  var bgdc_pkg::t_state                   i_state,
    input  wire                                    i_raw_level,
    input  wire  [bgdc_pkg::TimeW-1:0]             i_now_ms,
    output bgdc_pkg::t_state                       o_state,
    output bgdc_pkg::t_result                      o_result
);

    logic [bgdc_pkg::TimeW-1:0] d_deb, d_pend, d_press, d_rep;
    logic raw_chg, deb_ok, take, press, release_edge;
    logic dbl_in_window, click_set_now, long_ok, rep_ok, pend_ok;
    bgdc_pkg::t_state s;
    bgdc_pkg::t_gesture g;

    // all elapsed times against the old stamps, in parallel
    assign d_deb   = i_now_ms - i_state.raw_change_time;
    assign d_pend  = i_now_ms - i_state.pending_click_time;
    assign d_press = i_now_ms - i_state.press_start_time;
    assign d_rep   = i_now_ms - i_state.last_repeat_time;

    always_comb begin
        s = i_state;
        g = bgdc_pkg::G_NONE;

        raw_chg = (i_raw_level != i_state.previous_raw);
        if (raw_chg) begin
            s.previous_raw    = i_raw_level;
            s.raw_change_time = i_now_ms;
        end
        // a stamp taken this sample means zero elapsed time
        deb_ok = raw_chg ? (i_cfg.deb_time == '0)
                         : (d_deb >= {{(bgdc_pkg::TimeW-bgdc_pkg::DebW){1'b0}},
                                      i_cfg.deb_time});
        take         = (i_raw_level != i_state.filtered_level) && deb_ok;
        press        = take && !i_raw_level;
        release_edge = take && i_raw_level;
        if (take) begin
            s.filtered_level = i_raw_level;
        end

        dbl_in_window = (d_pend <= {{(bgdc_pkg::TimeW-bgdc_pkg::DblW){1'b0}},
                                    i_cfg.dbl_window});
        click_set_now = 1'b0;
        if (press) begin
            s.press_start_time = i_now_ms;
            s.long_active      = 1'b0;
            s.double_candidate = i_state.click_pending && dbl_in_window;
            s.click_pending    = 1'b0;
        end else if (release_edge) begin
            if (i_state.long_active) begin
                s.long_active = 1'b0;
            end else if (i_state.double_candidate) begin
                s.counter_value    = bgdc_pkg::digit_down(s.counter_value);
                g                  = bgdc_pkg::G_DOUBLE;
                s.double_candidate = 1'b0;
            end else begin
                s.click_pending      = 1'b1;
                s.pending_click_time = i_now_ms;
                click_set_now        = 1'b1;
            end
        end

        long_ok = press ? (i_cfg.hold_time == '0)
                        : (d_press >= {{(bgdc_pkg::TimeW-bgdc_pkg::LongW){1'b0}},
                                       i_cfg.hold_time});
        rep_ok  = (d_rep >= {{(bgdc_pkg::TimeW-bgdc_pkg::RepW){1'b0}}, i_cfg.rep_period});
        if (!s.filtered_level) begin
            if (!s.long_active && long_ok) begin
                s.long_active      = 1'b1;
                s.double_candidate = 1'b0;
                s.last_repeat_time = i_now_ms;
                s.counter_value    = bgdc_pkg::digit_up(s.counter_value);
                g                  = bgdc_pkg::G_LONG;
            end else if (s.long_active && rep_ok) begin
                s.last_repeat_time = i_now_ms;
                s.counter_value    = bgdc_pkg::digit_up(s.counter_value);
                g                  = bgdc_pkg::G_REPEAT;
            end
        end

        pend_ok = click_set_now ? (i_cfg.dbl_window == '0)
                                : (d_pend >= {{(bgdc_pkg::TimeW-bgdc_pkg::DblW){1'b0}},
                                              i_cfg.dbl_window});
        if (s.click_pending && pend_ok) begin
            s.click_pending = 1'b0;
            s.counter_value = bgdc_pkg::digit_up(s.counter_value);
            g               = bgdc_pkg::G_SINGLE;
        end

        o_state                  = s;
        o_result.gesture         = g;
        o_result.debounced_level = s.filtered_level;
        o_result.digit           = s.counter_value;
        o_result.segments        = i_cfg.common_anode ? ~bgdc_pkg::seg_lookup(s.counter_value)
                                                      : bgdc_pkg::seg_lookup(s.counter_value);
    end

endmodule

`default_nettype wire

### rtl/core/bgdc_checker.sv
`default_nettype none

module bgdc_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           s_axis_tready,
    input wire                           m_axis_tvalid,
    input wire                           m_axis_tready,
    input wire [bgdc_pkg::OutDataW-1:0]  m_axis_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:0] <= bgdc_pkg::DigitMax)
        else $error("digit out of range");

    a_gesture_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[14:12] <= bgdc_pkg::G_REPEAT)
        else $error("gesture code out of range");

    // with no result held the skid entry is empty, so input must be open
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind button_gesture_digit_counter bgdc_checker u_bgdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### verif/tb_button_gesture_digit_counter.sv
`timescale 1ns / 1ps

module tb_button_gesture_digit_counter;

    import bgdc_pkg::*;

    localparam int QUIET_LIMIT      = 2000;
    localparam int SINK_HOLD_CYCLES = 120;
    // segment patterns a..g for digits 9 down to 0, digit 0 in the low bits
    localparam logic [69:0] SEG_ROM = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                       7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic [InDataW-1:0]  s_axis_tdata  = '0;
    logic                m_axis_tready = 1'b0;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [AddrW-1:0]    paddr         = '0;
    logic [ApbDataW-1:0] pwdata        = '0;
    logic                s_axis_tready;
    logic                m_axis_tvalid;
    logic [OutDataW-1:0] m_axis_tdata;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    t_cfg        gest_cfg;
    t_state      gest_st;
    t_result     pending_displays[$];
    int          mismatch_count  = 0;
    int          samples_sent    = 0;
    logic [31:0] sample_ms       = '0;
    bit          steady_source   = 1'b0;
    bit          steady_sink     = 1'b0;
    int          sink_hold_asked = 0;
    int          sink_hold_taken = 0;
    int          sink_hold_left  = 0;

    button_gesture_digit_counter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // tdata: raw_level [0], now_ms [32:1], zero [39:33]
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // tdata: digit [3:0], segments [10:4], debounced_level [11], gesture [14:12], zero [15]
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------- display predictor ----------------

    function automatic logic [31:0] ms_since(input logic [31:0] now, input logic [31:0] since);
        return now - since;
    endfunction

    function automatic logic [DigitW-1:0] step_digit(input logic [DigitW-1:0] d, input bit up);
        if (up) begin
            return (d == 4'd9) ? 4'd0 : d + 4'd1;
        end
        return (d == 4'd0) ? 4'd9 : d - 4'd1;
    endfunction

    function automatic t_result predict_display(input logic raw, input logic [31:0] now);
        t_result  r;
        t_gesture g;
        bit       pressed;
        bit       released;
        g        = G_NONE;
        pressed  = 1'b0;
        released = 1'b0;
        if (raw != gest_st.previous_raw) begin
            gest_st.previous_raw    = raw;
            gest_st.raw_change_time = now;
        end
        if (raw != gest_st.filtered_level &&
            ms_since(now, gest_st.raw_change_time) >= gest_cfg.deb_time) begin
            gest_st.filtered_level = raw;
            pressed  = !raw;
            released = raw;
        end
        if (pressed) begin
            gest_st.press_start_time = now;
            gest_st.long_active      = 1'b0;
            gest_st.double_candidate = gest_st.click_pending &&
                (ms_since(now, gest_st.pending_click_time) <= gest_cfg.dbl_window);
            gest_st.click_pending    = 1'b0;
        end else if (released) begin
            if (gest_st.long_active) begin
                gest_st.long_active = 1'b0;
            end else if (gest_st.double_candidate) begin
                gest_st.counter_value    = step_digit(gest_st.counter_value, 1'b0);
                g                        = G_DOUBLE;
                gest_st.double_candidate = 1'b0;
            end else begin
                gest_st.click_pending      = 1'b1;
                gest_st.pending_click_time = now;
            end
        end
        // held button: first long-press step, then auto-repeat
        if (gest_st.filtered_level == 1'b0) begin
            if (!gest_st.long_active &&
                ms_since(now, gest_st.press_start_time) >= gest_cfg.hold_time) begin
                gest_st.long_active      = 1'b1;
                gest_st.double_candidate = 1'b0;
                gest_st.last_repeat_time = now;
                gest_st.counter_value    = step_digit(gest_st.counter_value, 1'b1);
                g                        = G_LONG;
            end else if (gest_st.long_active &&
                         ms_since(now, gest_st.last_repeat_time) >= gest_cfg.rep_period) begin
                gest_st.last_repeat_time = now;
                gest_st.counter_value    = step_digit(gest_st.counter_value, 1'b1);
                g                        = G_REPEAT;
            end
        end
        if (gest_st.click_pending &&
            ms_since(now, gest_st.pending_click_time) >= gest_cfg.dbl_window) begin
            gest_st.click_pending = 1'b0;
            gest_st.counter_value = step_digit(gest_st.counter_value, 1'b1);
            g                     = G_SINGLE;
        end
        r.digit           = gest_st.counter_value;
        r.segments        = SEG_ROM[gest_st.counter_value * 7 +: 7];
        if (gest_cfg.common_anode) begin
            r.segments = ~r.segments;
        end
        r.debounced_level = gest_st.filtered_level;
        r.gesture         = g;
        return r;
    endfunction

    // ---------------- stream drivers ----------------

    task automatic send_sample(input logic raw, input logic [31:0] now);
        if (!steady_source && $urandom_range(0, 99) < 19) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, now, raw};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        pending_displays.push_back(predict_display(raw, now));
        samples_sent++;
    endtask

    task automatic wait_displays_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_displays.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (sink_hold_taken != sink_hold_asked) begin
            sink_hold_taken = sink_hold_asked;
            sink_hold_left  = SINK_HOLD_CYCLES;
        end
        if (sink_hold_left > 0) begin
            sink_hold_left--;
            m_axis_tready <= 1'b0;
        end else if (steady_sink) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= 16);
        end
    end

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_displays
        t_result want;
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[14:0]);
            if (pending_displays.size() == 0) begin
                $display("%0t: result beat with none expected, actual %h", $time, m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_displays.pop_front();
                report_field("digit", want.digit, got.digit);
                report_field("segments", want.segments, got.segments);
                report_field("debounced_level", want.debounced_level, got.debounced_level);
                report_field("gesture", want.gesture, got.gesture);
                report_field("zero fill", 0, m_axis_tdata[15]);
            end
        end
    end

    // ---------------- register access ----------------

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            RegDebounce:    gest_cfg.deb_time     = val[DebW-1:0];
            RegDoubleClick: gest_cfg.dbl_window   = val[DblW-1:0];
            RegLongPress:   gest_cfg.hold_time    = val[LongW-1:0];
            RegRepeat:      gest_cfg.rep_period   = val[RepW-1:0];
            RegCommonAnode: gest_cfg.common_anode = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_thresholds(input int deb, input int dbl, input int lp, input int rp,
                                  input bit anode);
        cfg_write(RegDebounce, deb);
        cfg_write(RegDoubleClick, dbl);
        cfg_write(RegLongPress, lp);
        cfg_write(RegRepeat, rp);
        cfg_write(RegCommonAnode, {31'd0, anode});
    endtask

    // ---------------- stimulus ----------------

    task automatic hold_level(input logic raw, input int dur);
        int elapsed;
        int stride;
        send_sample(raw, sample_ms);
        elapsed = 0;
        while (elapsed < dur) begin
            stride     = $urandom_range(1, dur / 3 + 1);
            sample_ms += stride;
            elapsed   += stride;
            send_sample(raw, sample_ms);
        end
    endtask

    task automatic run_gestures(input int n);
        int target;
        int deb;
        int dbl;
        int lp;
        int rp;
        target = samples_sent + n;
        deb    = gest_cfg.deb_time;
        dbl    = gest_cfg.dbl_window;
        lp     = gest_cfg.hold_time;
        rp     = gest_cfg.rep_period;
        while (samples_sent < target) begin
            sample_ms += $urandom_range(1, 20);
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    hold_level(1'b0, deb + $urandom_range(1, lp / 2 + 1));
                    hold_level(1'b1, deb + dbl + $urandom_range(1, 200));
                end
                3, 4: begin
                    hold_level(1'b0, deb + $urandom_range(1, 50));
                    hold_level(1'b1, deb + $urandom_range(1, dbl / 2 + 1));
                    hold_level(1'b0, deb + $urandom_range(1, 50));
                    hold_level(1'b1, deb + dbl + $urandom_range(1, 200));
                end
                5, 6: begin
                    hold_level(1'b0, deb + lp + rp * $urandom_range(0, 3) + $urandom_range(1, 100));
                    hold_level(1'b1, deb + $urandom_range(1, dbl + 100));
                end
                7: begin
                    // contact bounce shorter than the debounce time
                    repeat ($urandom_range(2, 5)) begin
                        sample_ms += $urandom_range(1, deb / 2 + 1);
                        send_sample(1'($urandom_range(0, 1)), sample_ms);
                    end
                end
                8: begin
                    // second press turns into a long press
                    hold_level(1'b0, deb + $urandom_range(1, 50));
                    hold_level(1'b1, deb + $urandom_range(1, dbl / 2 + 1));
                    hold_level(1'b0, deb + lp + $urandom_range(1, rp + 50));
                    hold_level(1'b1, deb + $urandom_range(1, 100));
                end
                default: begin
                    // timestamp jumps anywhere, backwards included
                    if ($urandom_range(0, 1)) begin
                        sample_ms = $urandom();
                    end else begin
                        sample_ms -= $urandom_range(1, 2000);
                    end
                    send_sample(1'($urandom_range(0, 1)), sample_ms);
                end
            endcase
        end
    endtask

    task automatic test_default_gestures();
        send_sample(1'b1, 32'd0);
        // single click, settles after the double-click window
        send_sample(1'b0, 32'd10);
        send_sample(1'b0, 32'd40);
        send_sample(1'b1, 32'd100);
        send_sample(1'b1, 32'd130);
        send_sample(1'b1, 32'd490);
        // double click
        send_sample(1'b0, 32'd500);
        send_sample(1'b0, 32'd530);
        send_sample(1'b1, 32'd560);
        send_sample(1'b1, 32'd590);
        send_sample(1'b0, 32'd600);
        send_sample(1'b0, 32'd630);
        send_sample(1'b1, 32'd640);
        send_sample(1'b1, 32'd670);
        // long press, one repeat, release adds nothing
        send_sample(1'b0, 32'd700);
        send_sample(1'b0, 32'd730);
        send_sample(1'b0, 32'd1530);
        send_sample(1'b0, 32'd2030);
        send_sample(1'b1, 32'd2100);
        send_sample(1'b1, 32'd2130);
        send_sample(1'b1, 32'd2600);
        sample_ms = 32'd3000;
    endtask

    task automatic test_time_wrap();
        send_sample(1'b0, 32'hFFFF_FFF0);
        send_sample(1'b0, 32'h0000_0010);
        // time going backwards reads as a long hold
        send_sample(1'b1, 32'h0000_0008);
        send_sample(1'b1, 32'hFFFF_FFFF);
        sample_ms = 32'd5000;
        wait_displays_drained();
    endtask

    task automatic test_zero_thresholds();
        set_thresholds(0, 0, 0, 0, 1'b1);
        send_sample(1'b0, sample_ms);
        send_sample(1'b0, sample_ms + 1);
        send_sample(1'b0, sample_ms + 1);
        send_sample(1'b1, sample_ms + 2);
        send_sample(1'b0, sample_ms + 3);
        send_sample(1'b1, sample_ms + 3);
        sample_ms += 10;
        run_gestures(40);
        wait_displays_drained();
    endtask

    task automatic test_max_thresholds();
        set_thresholds(1000, 5000, 10000, 5000, 1'b0);
        run_gestures(80);
        wait_displays_drained();
    endtask

    task automatic test_no_idle_stretch();
        set_thresholds(20, 200, 300, 1, 1'b0);
        steady_source = 1'b1;
        steady_sink   = 1'b1;
        run_gestures(80);
        wait_displays_drained();
        steady_source = 1'b0;
        steady_sink   = 1'b0;
    endtask

    task automatic test_output_stall();
        steady_source = 1'b1;
        sink_hold_asked++;
        run_gestures(30);
        steady_source = 1'b0;
        wait_displays_drained();
    endtask

    task automatic test_random_settings();
        for (int round = 0; round < 3; round++) begin
            if (round == 0) begin
                set_thresholds($urandom_range(0, 40), $urandom_range(0, 400),
                               $urandom_range(0, 1000), $urandom_range(1, 600),
                               1'($urandom_range(0, 1)));
            end else begin
                set_thresholds($urandom_range(0, 1000), $urandom_range(0, 5000),
                               $urandom_range(0, 10000), $urandom_range(1, 5000),
                               1'($urandom_range(0, 1)));
            end
            run_gestures(30);
            // source waits for every result, then carries on with the same setting
            wait_displays_drained();
            run_gestures(30);
            wait_displays_drained();
        end
    endtask

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (!s_axis_tvalid && pending_displays.size() == 0)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        gest_cfg.deb_time        = DebounceRst;
        gest_cfg.dbl_window      = DoubleClickRst;
        gest_cfg.hold_time       = LongPressRst;
        gest_cfg.rep_period      = RepeatRst;
        gest_cfg.common_anode    = 1'b0;
        gest_st                  = '0;
        gest_st.filtered_level   = 1'b1;
        gest_st.previous_raw     = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_gestures();
        test_time_wrap();
        test_zero_thresholds();
        test_max_thresholds();
        test_no_idle_stretch();
        test_output_stall();
        test_random_settings();

        wait_displays_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
